// ===== sv/dros_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP relay option scanner package
// Parse phases, option codes, verdict codes and the magic cookie.
// ----------------------------------------------------------------------------
package dros_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_COOKIE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CODE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_AGENT    = 8'd82;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [2:0] COOKIE_LEN = 3'd4;

  typedef logic [1:0] verdict_t;
  localparam verdict_t V_FORWARD = 2'd0;
  localparam verdict_t V_AGENT   = 2'd1;
  localparam verdict_t V_BAD_LEN = 2'd2;

  // One accepted byte as seen by the parser
  typedef struct packed {
    logic       fire;
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = 8'd99;
      2'd1: m = 8'd130;
      2'd2: m = 8'd83;
      2'd3: m = 8'd99;
      default: m = 8'd99;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/dros_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP relay option scanner channels
// Valid/ready channels for option bytes and for verdicts.
// ----------------------------------------------------------------------------
interface dros_byte_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dros_verdict_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

// ===== sv/dros_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP relay option scanner: option walker
// Holds the per-packet parse state and forms the verdict for the last byte.
// ----------------------------------------------------------------------------
module dros_parser
  import dros_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  step_t    step,
  output verdict_t verdict
);

  logic [2:0]         cookie_count, cookie_count_next;
  logic [PHASE_W-1:0] parse_phase, parse_phase_next;
  logic [7:0]         bytes_left, bytes_left_next;
  logic               seen_msg_type, seen_msg_type_next;
  verdict_t           held_verdict, held_verdict_next;
  verdict_t           pending;
  logic [7:0]         b;

  assign b = step.data_byte;

  always_comb begin
    cookie_count_next  = cookie_count;
    parse_phase_next   = parse_phase;
    bytes_left_next    = bytes_left;
    seen_msg_type_next = seen_msg_type;
    held_verdict_next  = held_verdict;
    pending            = V_FORWARD;
    unique case (parse_phase)
      PH_COOKIE: begin
        if (b != magic_byte(cookie_count[1:0])) begin
          held_verdict_next = V_FORWARD;
          parse_phase_next  = PH_DONE;
        end else begin
          cookie_count_next = cookie_count + 3'd1;
          if (cookie_count_next >= COOKIE_LEN) parse_phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        priority if (b == OPT_PAD) begin
          pending = V_FORWARD;
        end else if (b == OPT_END) begin
          held_verdict_next = V_FORWARD;
          parse_phase_next  = PH_DONE;
        end else if (b == OPT_AGENT && seen_msg_type) begin
          held_verdict_next = V_AGENT;
          parse_phase_next  = PH_DONE;
        end else begin
          if (b == OPT_MSG_TYPE) seen_msg_type_next = 1'b1;
          parse_phase_next = PH_LEN;
          pending          = V_BAD_LEN;
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          parse_phase_next = PH_CODE;
        end else begin
          bytes_left_next  = b;
          parse_phase_next = PH_SKIP;
          pending          = V_BAD_LEN;
        end
      end
      PH_SKIP: begin
        if (bytes_left != 8'd0) bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          parse_phase_next = PH_CODE;
        end else begin
          pending = V_BAD_LEN;
        end
      end
      default: ;  // verdict reached: bytes ignored
    endcase
  end

  assign verdict = (parse_phase_next >= PH_DONE) ? held_verdict_next : pending;

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last_byte)) begin
      cookie_count  <= 3'd0;
      parse_phase   <= PH_COOKIE;
      bytes_left    <= 8'd0;
      seen_msg_type <= 1'b0;
      held_verdict  <= V_FORWARD;
    end else if (step.fire) begin
      cookie_count  <= cookie_count_next;
      parse_phase   <= parse_phase_next;
      bytes_left    <= bytes_left_next;
      seen_msg_type <= seen_msg_type_next;
      held_verdict  <= held_verdict_next;
    end
  end

  // skipping always has data still to drop
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_SKIP |-> bytes_left != 8'd0)
    else $error("skip phase with no data bytes left");

  // cookie phase never counts past the cookie
  a_cookie_bound: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_COOKIE |-> cookie_count < COOKIE_LEN)
    else $error("cookie count beyond cookie length");

  // last beat returns the walker to the start of a packet
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.last_byte |=> parse_phase == PH_COOKIE && cookie_count == 3'd0)
    else $error("parse state not cleared after last beat");

endmodule

// ===== sv/dhcp_relay_option_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP relay option scanner
//   channel      dir  payload               beat
//   bytes_in     in   data_byte, last_byte  one options byte, cookie first
//   verdict_out  out  verdict               one per packet, after last byte
//
// One byte per cycle unless stalled; the last byte's verdict is registered.
// The output register holds one verdict; bytes are taken while it is empty or
// being drained, so a stalled verdict holds back every byte until it is read.
// Synchronous reset clears the parse state and empties the output register.
// ----------------------------------------------------------------------------
module dhcp_relay_option_scanner
  import dros_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  dros_byte_if.sink      bytes_in,
  dros_verdict_if.source verdict_out
);

  step_t    step;
  verdict_t step_verdict;
  logic     out_valid;
  verdict_t out_verdict;
  logic     take;

  assign take           = bytes_in.valid && bytes_in.ready;
  assign bytes_in.ready = !out_valid || verdict_out.ready;

  assign step.fire      = take;
  assign step.data_byte = bytes_in.data_byte;
  assign step.last_byte = bytes_in.last_byte;

  dros_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .verdict (step_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && bytes_in.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && bytes_in.last_byte) out_verdict <= step_verdict;
  end

  assign verdict_out.valid   = out_valid;
  assign verdict_out.verdict = out_verdict;

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    take && bytes_in.last_byte |=> verdict_out.valid)
    else $error("no verdict after last beat");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    verdict_out.valid |-> verdict_out.verdict != 2'd3)
    else $error("undefined verdict code");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict_out.ready |-> !bytes_in.ready)
    else $error("input taken while verdict stalled");

endmodule

// ===== test/dhcp_relay_option_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP relay option scanner testbench
// Streams option bytes as whole packets, mostly well-formed ones with random
// options and lengths, plus broken cookies, noise and truncated packets. The
// scoreboard scans each accepted byte itself and checks one verdict per
// packet, in order. Both channels idle at random; the verdict side also
// holds off for a long stretch.
// ----------------------------------------------------------------------------
module dhcp_relay_option_scanner_test;
  import dros_pkg::*;

  localparam logic [31:0] COOKIE_WORD = 32'h63825363;

  // Parses the options area byte by byte and queues the verdict due at
  // each packet end
  class option_verdict_board;
    logic [2:0]         cookie_cnt;
    logic [PHASE_W-1:0] phase;
    logic [8:0]         left;
    logic               msg_seen;
    verdict_t           held;
    verdict_t           verdict_q[$];
    int unsigned        errors;
    int unsigned        shown;

    function new();
      clear_scan();
      errors = 0;
      shown  = 0;
    endfunction

    function void clear_scan();
      cookie_cnt = '0;
      phase      = PH_COOKIE;
      left       = '0;
      msg_seen   = 1'b0;
      held       = V_FORWARD;
    endfunction

    function void settle(verdict_t v);
      held  = v;
      phase = PH_DONE;
    endfunction

    function void flag(string what, verdict_t want, verdict_t got);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      verdict_t pend;
      pend = V_FORWARD;
      case (phase)
        PH_COOKIE: begin
          if (b != COOKIE_WORD[8*(3-cookie_cnt[1:0]) +: 8]) begin
            settle(V_FORWARD);
          end else begin
            cookie_cnt = cookie_cnt + 3'd1;
            if (cookie_cnt >= COOKIE_LEN) phase = PH_CODE;
          end
        end
        PH_CODE: begin
          if (b == OPT_PAD) begin
            pend = V_FORWARD;
          end else if (b == OPT_END) begin
            settle(V_FORWARD);
          end else if (b == OPT_AGENT && msg_seen) begin
            settle(V_AGENT);
          end else begin
            if (b == OPT_MSG_TYPE) msg_seen = 1'b1;
            phase = PH_LEN;
            pend  = V_BAD_LEN;
          end
        end
        PH_LEN: begin
          if (b == 8'd0) begin
            phase = PH_CODE;
          end else begin
            left  = {1'b0, b};
            phase = PH_SKIP;
            pend  = V_BAD_LEN;
          end
        end
        PH_SKIP: begin
          if (left != 0) left = left - 9'd1;
          if (left == 0) phase = PH_CODE;
          else pend = V_BAD_LEN;
        end
        default: ;
      endcase
      if (last) begin
        if (phase >= PH_DONE) pend = held;
        verdict_q.push_back(pend);
        clear_scan();
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag("verdict with no packet end pending", V_FORWARD, got);
      end else begin
        want = verdict_q.pop_front();
        if (want != got) flag("verdict mismatch", want, got);
      end
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dros_byte_if    bytes_ch (clk);
  dros_verdict_if verdict_ch (clk);

  dhcp_relay_option_scanner u_dut (
    .clk         (clk),
    .rst         (rst),
    .bytes_in    (bytes_ch),
    .verdict_out (verdict_ch)
  );

  option_verdict_board board = new();

  logic [7:0] pkt[$];
  bit         src_gaps;
  bit         stall_req;

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (src_gaps && $urandom_range(99) < 29) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid     <= 1'b1;
    bytes_ch.data_byte <= b;
    bytes_ch.last_byte <= last;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    board.note_byte(b, last);
  endtask

  task automatic drive_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic push_cookie();
    for (int i = 0; i < 4; i++) pkt.push_back(COOKIE_WORD[8*(3-i) +: 8]);
  endtask

  task automatic build_options();
    int unsigned n_opt;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  code;
    n_opt = $urandom_range(0, 5);
    repeat (n_opt) begin
      pick = $urandom_range(99);
      if (pick < 15)      code = OPT_PAD;
      else if (pick < 35) code = OPT_MSG_TYPE;
      else if (pick < 60) code = OPT_AGENT;
      else if (pick < 64) code = OPT_END;
      else                code = 8'($urandom_range(1, 254));
      pkt.push_back(code);
      if (code != OPT_PAD && code != OPT_END) begin
        len = ($urandom_range(99) < 3) ? $urandom_range(100, 255) : $urandom_range(0, 4);
        pkt.push_back(len[7:0]);
        repeat (len) pkt.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic build_packet();
    int unsigned kind;
    int unsigned cut;
    int unsigned idx;
    logic [7:0]  flip;
    pkt.delete();
    kind = $urandom_range(99);
    if (kind < 72) begin
      push_cookie();
      build_options();
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(255)));
      end
      // chop the tail: ends inside an option, its length or the cookie
      if ($urandom_range(99) < 25) begin
        cut = $urandom_range(1, pkt.size() - 1);
        repeat (cut) void'(pkt.pop_back());
      end
    end else if (kind < 86) begin
      push_cookie();
      idx  = $urandom_range(3);
      flip = 8'($urandom_range(1, 255));
      pkt[idx] = pkt[idx] ^ flip;
      repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(255)));
    end
  endtask

  // verdict side: random stalls, steady windows, one long hold-off on request
  initial begin : verdict_sink
    int unsigned hold;
    int unsigned cyc;
    hold = 0;
    cyc  = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && verdict_ch.valid && verdict_ch.ready) board.check_verdict(verdict_ch.verdict);
      cyc++;
      if (stall_req) begin
        hold      = 200;
        stall_req = 1'b0;
      end
      if (hold != 0) begin
        hold--;
        verdict_ch.ready <= 1'b0;
      end else if (rst) begin
        verdict_ch.ready <= 1'b0;
      end else if (cyc % 1500 < 300) begin
        verdict_ch.ready <= 1'b1;
      end else begin
        verdict_ch.ready <= ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin : byte_source
    int unsigned rand_bytes;
    int unsigned pkt_no;
    rand_bytes = 0;
    pkt_no     = 0;
    src_gaps   = 1'b1;
    stall_req  = 1'b0;
    rst                <= 1'b1;
    bytes_ch.valid     <= 1'b0;
    bytes_ch.data_byte <= 8'd0;
    bytes_ch.last_byte <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ends inside the cookie
    pkt = '{8'd99};
    drive_packet();
    // cookie mismatch, rest ignored
    pkt = '{8'd99, 8'd7, 8'd99};
    drive_packet();
    // message type, then agent code as the final byte
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, OPT_MSG_TYPE, 8'd1, 8'd5, OPT_AGENT};
    drive_packet();
    // length byte last and non-zero
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd12, 8'd255};
    drive_packet();
    // pad then End as the final byte
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, OPT_PAD, OPT_END};
    drive_packet();

    while (rand_bytes < 550) begin
      src_gaps = (pkt_no % 40 >= 8);
      if (pkt_no == 12) stall_req = 1'b1;
      if (pkt_no == 30) begin
        bytes_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end
      build_packet();
      drive_packet();
      rand_bytes += pkt.size();
      pkt_no++;
    end
    bytes_ch.valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
